// ----- design/pse_pkg.sv -----
package pse_pkg;

    localparam int DATA_W = 64;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_OPER = 2'd1,
        ACT_END  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5,
        OP_BAD6 = 3'd6,
        OP_BAD7 = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_BAD_OP    = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_DIV_ZERO  = 3'd4,
        ST_NEG_EXP   = 3'd5
    } status_t;

    typedef struct packed {
        action_t           action;
        op_t               op;
        logic [DATA_W-1:0] value;
    } token_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RDWAIT,
        S_EXEC,
        S_DIV,
        S_DIVFIX,
        S_POW,
        S_MUL,
        S_WRITE,
        S_END_RD,
        S_END_WAIT,
        S_OUT
    } state_t;

endpackage

// ----- design/postfix_stack_evaluator.sv -----
// postfix expression evaluator
// s_ channel takes one token word per handshake, m_ channel gives one
// result word for each end-of-expression token.
// s_tdata: action[1:0], token_value[65:2], operator_code[68:66]
// m_tdata: status[2:0], final_value[66:3]
// a two-word queue decouples the input from the execution engine.
// push tokens are written to the stack straight from the idle state;
// div/mod use a restoring divider, one bit per cycle;
// power uses square-and-multiply, each 64-bit multiply built
// from three 32x32 partial products.
// end tokens are held until the output register is free.
// the result stays in the output register until m_tready; meanwhile the
// engine keeps working on non-end tokens, and once the queue is full
// s_tready drops until the engine takes a word.
// reset empties the queue and the stack and clears the sticky error.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action, token_value, operator_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status, final_value
);

    logic            q_valid;
    logic            q_pop;
    pse_pkg::token_t q_token;

    pse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_token (q_token)
    );

    pse_back #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_token (q_token),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

// ----- design/pse_front.sv -----
module pse_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [71:0]          s_tdata,
    output logic                 q_valid,
    input  logic                 q_pop,
    output pse_pkg::token_t      q_token
);

    pse_pkg::token_t              fifo_reg [pse_pkg::QUEUE_DEPTH];
    logic [pse_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [pse_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [pse_pkg::Q_PTR_W:0]    count_reg;
    pse_pkg::token_t              tok;
    logic                         push;

    // drop unused action at the front
    always_comb begin
        tok.action = pse_pkg::action_t'(s_tdata[1:0]);
        tok.value  = s_tdata[65:2];
        tok.op     = pse_pkg::op_t'(s_tdata[68:66]);
    end

    assign s_tready = (count_reg != (pse_pkg::Q_PTR_W+1)'(pse_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready && (tok.action != pse_pkg::ACT_NONE);
    assign q_valid  = (count_reg != '0);
    assign q_token  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= tok;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (pse_pkg::Q_PTR_W+1)'(push)
                         - (pse_pkg::Q_PTR_W+1)'(q_pop);
        end
    end

endmodule

// ----- design/pse_back.sv -----
module pse_back #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  pse_pkg::token_t      q_token,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int W = pse_pkg::DATA_W;
    localparam int HW = W / 2;

    logic [W-1:0]         mem [STACK_DEPTH];
    logic [W-1:0]         rd_data_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [W-1:0]         mem_wdata;
    logic [AW-1:0]        mem_raddr;

    pse_pkg::state_t      state_reg, state_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    pse_pkg::status_t     err_reg, err_next;
    pse_pkg::op_t         op_reg, op_next;
    logic [W-1:0]         a_reg, a_next;
    logic [W-1:0]         b_reg, b_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         prod_reg, prod_next;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 neg_q_reg, neg_q_next;
    logic                 neg_r_reg, neg_r_next;
    logic                 out_valid_reg, out_valid_next;
    pse_pkg::status_t     out_st_reg, out_st_next;
    logic [W-1:0]         out_val_reg, out_val_next;
    logic                 pow_phase_reg, pow_phase_next;

    logic [W:0]           rem_shift;
    logic [W:0]           rem_sub;
    logic [W-1:0]         mul_x;
    logic [HW-1:0]        mul_a;
    logic [HW-1:0]        mul_b;
    logic [W-1:0]         mul_p;
    logic [W-1:0]         mul_sum;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign rem_shift = {rem_reg, acc_reg[W-1]};
    assign rem_sub   = rem_shift - {1'b0, b_reg};

    // 64-bit wrap multiply from three 32x32 partial products, one per cycle
    assign mul_x = pow_phase_reg ? b_reg : acc_reg;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin
                mul_a = mul_x[HW-1:0];
                mul_b = b_reg[HW-1:0];
            end
            2'd1: begin
                mul_a = mul_x[HW-1:0];
                mul_b = b_reg[W-1:HW];
            end
            default: begin
                mul_a = mul_x[W-1:HW];
                mul_b = b_reg[HW-1:0];
            end
        endcase
    end

    assign mul_p   = W'(mul_a) * W'(mul_b);
    assign mul_sum = (cnt_reg[1:0] == 2'd0) ? mul_p :
                     (prod_reg + {mul_p[HW-1:0], {HW{1'b0}}});

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_val_reg, out_st_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pse_pkg::S_IDLE;
            sp_reg        <= '0;
            err_reg       <= pse_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        prod_reg      <= prod_next;
        cnt_reg       <= cnt_next;
        neg_q_reg     <= neg_q_next;
        neg_r_reg     <= neg_r_next;
        out_st_reg    <= out_st_next;
        out_val_reg   <= out_val_next;
        pow_phase_reg <= pow_phase_next;
    end

    always_comb begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        err_next       = err_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        out_st_next    = out_st_reg;
        out_val_next   = out_val_reg;
        pow_phase_next = pow_phase_reg;
        out_valid_next = out_valid_reg && !m_tready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = sp_reg[AW-1:0];
        mem_wdata      = q_token.value;
        mem_raddr      = '0;

        unique case (state_reg)
            pse_pkg::S_IDLE: begin
                if (q_valid) begin
                    unique case (q_token.action)
                        pse_pkg::ACT_PUSH: begin
                            q_pop = 1'b1;
                            if (err_reg == pse_pkg::ST_OK) begin
                                if (sp_reg >= SPW'(STACK_DEPTH)) begin
                                    err_next = pse_pkg::ST_OVERFLOW;
                                end else begin
                                    mem_we  = 1'b1;
                                    sp_next = sp_reg + 1'b1;
                                end
                            end
                        end
                        pse_pkg::ACT_OPER: begin
                            q_pop = 1'b1;
                            if (err_reg == pse_pkg::ST_OK) begin
                                if (sp_reg < SPW'(2)) begin
                                    err_next = pse_pkg::ST_MALFORMED;
                                end else if (q_token.op inside {pse_pkg::OP_BAD6,
                                                                pse_pkg::OP_BAD7}) begin
                                    err_next = pse_pkg::ST_BAD_OP;
                                    sp_next  = sp_reg - SPW'(2);
                                end else begin
                                    op_next    = q_token.op;
                                    mem_raddr  = AW'(sp_reg - SPW'(1));
                                    state_next = pse_pkg::S_RD1;
                                end
                            end
                        end
                        pse_pkg::ACT_END: begin
                            if (!out_valid_reg || m_tready) begin
                                if (err_reg == pse_pkg::ST_OK && sp_reg == SPW'(1)) begin
                                    mem_raddr  = '0;
                                    state_next = pse_pkg::S_END_RD;
                                end else begin
                                    q_pop          = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_st_next    = (err_reg == pse_pkg::ST_OK) ?
                                                     pse_pkg::ST_MALFORMED : err_reg;
                                    out_val_next   = '0;
                                    sp_next        = '0;
                                    err_next       = pse_pkg::ST_OK;
                                end
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            pse_pkg::S_RD1: begin
                b_next     = rd_data_reg;
                mem_raddr  = AW'(sp_reg - SPW'(2));
                state_next = pse_pkg::S_RD2;
            end
            pse_pkg::S_RD2: begin
                a_next     = rd_data_reg;
                state_next = pse_pkg::S_RDWAIT;
            end
            pse_pkg::S_RDWAIT: begin
                sp_next    = sp_reg - SPW'(2);
                state_next = pse_pkg::S_EXEC;
            end
            pse_pkg::S_EXEC: begin
                state_next = pse_pkg::S_WRITE;
                unique case (op_reg) inside
                    pse_pkg::OP_ADD: acc_next = a_reg + b_reg;
                    pse_pkg::OP_SUB: acc_next = a_reg - b_reg;
                    pse_pkg::OP_MUL: begin
                        acc_next       = a_reg;
                        pow_phase_next = 1'b0;
                        cnt_next       = '0;
                        state_next     = pse_pkg::S_MUL;
                    end
                    pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
                        if (b_reg == '0) begin
                            err_next   = pse_pkg::ST_DIV_ZERO;
                            state_next = pse_pkg::S_IDLE;
                        end else begin
                            neg_q_next = a_reg[W-1] ^ b_reg[W-1];
                            neg_r_next = a_reg[W-1];
                            acc_next   = a_reg[W-1] ? -a_reg : a_reg;
                            b_next     = b_reg[W-1] ? -b_reg : b_reg;
                            rem_next   = '0;
                            cnt_next   = 7'(W);
                            state_next = pse_pkg::S_DIV;
                        end
                    end
                    pse_pkg::OP_POW: begin
                        if (b_reg[W-1]) begin
                            err_next   = pse_pkg::ST_NEG_EXP;
                            state_next = pse_pkg::S_IDLE;
                        end else begin
                            rem_next       = b_reg;
                            b_next         = a_reg;
                            acc_next       = W'(1);
                            pow_phase_next = 1'b0;
                            cnt_next       = '0;
                            state_next     = pse_pkg::S_POW;
                        end
                    end
                    default: state_next = pse_pkg::S_IDLE;
                endcase
            end
            pse_pkg::S_MUL: begin
                // acc * b over three partial products
                prod_next = mul_sum;
                if (cnt_reg == 7'd2) begin
                    acc_next   = mul_sum;
                    state_next = pse_pkg::S_WRITE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            pse_pkg::S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (!rem_sub[W]) begin
                    rem_next = rem_sub[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[W-1:0];
                    acc_next = {acc_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 7'd1) begin
                    state_next = pse_pkg::S_DIVFIX;
                end
            end
            pse_pkg::S_DIVFIX: begin
                if (op_reg == pse_pkg::OP_MOD) begin
                    acc_next = neg_r_reg ? -rem_reg : rem_reg;
                end else begin
                    acc_next = neg_q_reg ? -acc_reg : acc_reg;
                end
                state_next = pse_pkg::S_WRITE;
            end
            pse_pkg::S_POW: begin
                // alternate multiply into acc and squaring of base
                if (!pow_phase_reg) begin
                    if (rem_reg == '0) begin
                        state_next = pse_pkg::S_WRITE;
                    end else if (!rem_reg[0]) begin
                        pow_phase_next = 1'b1;
                    end else begin
                        prod_next = mul_sum;
                        if (cnt_reg == 7'd2) begin
                            acc_next       = mul_sum;
                            cnt_next       = '0;
                            pow_phase_next = 1'b1;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end else begin
                    prod_next = mul_sum;
                    if (cnt_reg == 7'd2) begin
                        b_next         = mul_sum;
                        rem_next       = rem_reg >> 1;
                        cnt_next       = '0;
                        pow_phase_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            pse_pkg::S_WRITE: begin
                mem_we     = 1'b1;
                mem_wdata  = acc_reg;
                sp_next    = sp_reg + 1'b1;
                state_next = pse_pkg::S_IDLE;
            end
            pse_pkg::S_END_RD: begin
                state_next = pse_pkg::S_END_WAIT;
            end
            pse_pkg::S_END_WAIT: begin
                state_next = pse_pkg::S_OUT;
            end
            pse_pkg::S_OUT: begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                out_st_next    = pse_pkg::ST_OK;
                out_val_next   = rd_data_reg;
                sp_next        = '0;
                err_next       = pse_pkg::ST_OK;
                state_next     = pse_pkg::S_IDLE;
            end
            default: state_next = pse_pkg::S_IDLE;
        endcase
    end

endmodule
